FILE: rtl/acr_pkg.sv
// arc cache replacement: shared constants, list codes, sweep opcodes and types
// used by acr_dir and arc_cache_replacement; no dependencies
package acr_pkg;

  localparam int CAPACITY  = 64;
  localparam int DIR_DEPTH = 2 * CAPACITY;
  localparam int IDX_W     = $clog2(DIR_DEPTH);
  localparam int KEY_W     = 32;
  localparam int CAP_W     = 7;
  localparam int CNT_W     = IDX_W + 1;
  localparam int RANK_W    = IDX_W;
  localparam int LIST_W    = 2;
  localparam int FOUND_W   = 3;

  // list codes, equal to the found_in codes of the lists
  localparam logic [LIST_W-1:0] L_T1 = 2'd0;
  localparam logic [LIST_W-1:0] L_T2 = 2'd1;
  localparam logic [LIST_W-1:0] L_B1 = 2'd2;
  localparam logic [LIST_W-1:0] L_B2 = 2'd3;

  localparam logic [FOUND_W-1:0] F_NOWHERE = 3'd4;

  // sweep opcodes
  localparam logic [1:0] OP_FIND   = 2'd0;
  localparam logic [1:0] OP_LRU    = 2'd1;
  localparam logic [1:0] OP_FREE   = 2'd2;
  localparam logic [1:0] OP_RELINK = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [LIST_W-1:0] list;
    logic [RANK_W-1:0] rank;
  } entry_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [KEY_W-1:0]  key;
    logic [IDX_W-1:0]  idx;
    logic [LIST_W-1:0] list;      // search list, or list linked into
    logic [RANK_W-1:0] rank;      // search rank, or rank unlinked from
    logic [LIST_W-1:0] old_list;
    logic              has_old;
    logic              has_new;
  } dir_cmd_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [LIST_W-1:0] list;
    logic [RANK_W-1:0] rank;
  } dir_res_t;

endpackage

FILE: rtl/acr_ram.sv
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module acr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/acr_dir.sv
// arc directory: entry ram, valid bits and the sweep unit that walks all
// entries one per cycle for find, lru, free-slot and relink; uses acr_pkg, acr_ram
module acr_dir (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              flush,
  input  logic              go,
  input  acr_pkg::dir_cmd_t cmd,
  output logic              done,
  output acr_pkg::dir_res_t res
);
  import acr_pkg::*;

  logic [DIR_DEPTH-1:0] valid_r;
  dir_cmd_t             cmd_r;
  logic                 run_r, run_nxt;
  logic [IDX_W-1:0]     cnt_r, cnt_nxt;
  logic                 pv_r, pv_nxt;
  logic [IDX_W-1:0]     pidx_r, pidx_nxt;
  logic                 done_r, done_nxt;
  dir_res_t             res_r, res_nxt;
  entry_t               rdata, wdata;
  logic                 we, vwe, vval, v, match, dec, inc;

  acr_ram #(.WIDTH($bits(entry_t)), .DEPTH(DIR_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (pidx_r),
    .wdata (wdata),
    .raddr (cnt_r),
    .rdata (rdata)
  );

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    pv_nxt   = 1'b0;
    pidx_nxt = pidx_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    we       = 1'b0;
    vwe      = 1'b0;
    vval     = 1'b0;
    wdata    = rdata;
    match    = 1'b0;
    v        = valid_r[pidx_r];
    dec      = cmd_r.has_old && rdata.list == cmd_r.old_list && rdata.rank > cmd_r.rank;
    inc      = cmd_r.has_new && rdata.list == cmd_r.list;
    if (go) begin
      run_nxt       = 1'b1;
      cnt_nxt       = '0;
      res_nxt.found = 1'b0;
    end else if (run_r) begin
      pv_nxt   = 1'b1;
      pidx_nxt = cnt_r;
      if (cnt_r == IDX_W'(DIR_DEPTH - 1)) begin
        run_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (pv_r) begin
      done_nxt = (pidx_r == IDX_W'(DIR_DEPTH - 1));
      case (cmd_r.op)
        OP_FIND:  match = v && rdata.key == cmd_r.key;
        OP_LRU:   match = v && rdata.list == cmd_r.list && rdata.rank == cmd_r.rank;
        OP_FREE:  match = !v;
        default: begin
          if (pidx_r == cmd_r.idx) begin
            vwe        = 1'b1;
            vval       = cmd_r.has_new;
            we         = cmd_r.has_new;
            wdata.key  = v ? rdata.key : cmd_r.key;
            wdata.list = cmd_r.list;
            wdata.rank = '0;
          end else if (v) begin
            we         = dec || inc;
            wdata.rank = rdata.rank - RANK_W'(dec) + RANK_W'(inc);
          end
        end
      endcase
      if (match && !res_r.found) begin
        res_nxt.found = 1'b1;
        res_nxt.idx   = pidx_r;
        res_nxt.list  = rdata.list;
        res_nxt.rank  = rdata.rank;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= 1'b0;
      pv_r      <= 1'b0;
      done_r    <= 1'b0;
      res_r     <= '0;
      valid_r   <= '0;
    end else begin
      run_r     <= run_nxt;
      pv_r      <= pv_nxt;
      done_r    <= done_nxt;
      res_r     <= res_nxt;
      if (flush) begin
        valid_r <= '0;
      end else if (vwe) begin
        valid_r[pidx_r] <= vval;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    pidx_r       <= pidx_nxt;
    if (go) begin
      cmd_r <= cmd;
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: rtl/arc_cache_replacement.sv
// arc cache replacement top: access sequencer, list counts, adaptive target
// and configuration register; uses acr_pkg and acr_dir
//
// Usage: drive in_block_address with start high while busy is low; the beat
// is taken at that edge and busy rises. The policy runs as a chain of
// directory sweeps, each walking all 128 entries one per cycle through the
// single sweep unit in acr_dir. A resident hit takes two sweeps; a miss or
// ghost hit takes three to seven sweeps. When done, out_valid pulses for one
// cycle with out_hit, out_found_in and out_target_after; the receiver cannot
// stall, and busy falls in that same cycle so the next access may start.
// cfg_cache_capacity is written with cfg_valid while cfg_ready is high
// (idle only); a write clamps the capacity to 1..64, empties all four lists
// and reloads the target to half the capacity. After reset the capacity is
// 64, the target 32 and all lists are empty; no clearing pass is needed.
module arc_cache_replacement (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [acr_pkg::KEY_W-1:0]     in_block_address,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [acr_pkg::FOUND_W-1:0]   out_found_in,
  output logic [acr_pkg::CAP_W-1:0]     out_target_after,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [acr_pkg::CAP_W-1:0]     cfg_cache_capacity
);
  import acr_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] W_FIND     = 4'd1;
  localparam logic [3:0] S_TRIM     = 4'd2;
  localparam logic [3:0] W_TRIM_LRU = 4'd3;
  localparam logic [3:0] W_TRIM_UNL = 4'd4;
  localparam logic [3:0] S_REP      = 4'd5;
  localparam logic [3:0] W_REP_LRU  = 4'd6;
  localparam logic [3:0] W_REP_MOVE = 4'd7;
  localparam logic [3:0] S_AFTER    = 4'd8;
  localparam logic [3:0] S_FREE     = 4'd9;
  localparam logic [3:0] W_FREE     = 4'd10;
  localparam logic [3:0] W_FINAL    = 4'd11;

  logic [3:0]                 state_r, state_nxt;
  logic [CAP_W-1:0]           cap_r, cap_nxt;
  logic [CAP_W-1:0]           tgt_r, tgt_nxt;
  logic [3:0][CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [KEY_W-1:0]           key_r, key_nxt;
  logic [IDX_W-1:0]           hold_idx_r, hold_idx_nxt;
  logic [LIST_W-1:0]          hold_list_r, hold_list_nxt;
  logic [RANK_W-1:0]          hold_rank_r, hold_rank_nxt;
  logic                       miss_r, miss_nxt;
  logic                       rep_r, rep_nxt;
  logic                       in_b2_r, in_b2_nxt;
  logic                       trim_en_r, trim_en_nxt;
  logic [LIST_W-1:0]          trim_list_r, trim_list_nxt;
  logic [LIST_W-1:0]          rep_list_r, rep_list_nxt;
  logic                       hit_r, hit_nxt;
  logic [FOUND_W-1:0]         found_r, found_nxt;
  dir_cmd_t                   cmd_r, cmd_nxt;
  logic                       go_r, go_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_hit_r;
  logic [FOUND_W-1:0]         out_found_r;
  logic [CAP_W-1:0]           out_tgt_r;
  logic                       dir_done;
  dir_res_t                   dir_res;
  logic                       cfg_we;
  logic [CAP_W-1:0]           c;
  logic [CNT_W:0]             l1, tot;
  logic [CNT_W-1:0]           t1;
  logic                       from_t1;
  logic [LIST_W-1:0]          pick, ghost;

  function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] v);
    logic [CAP_W-1:0] r;
    r = v;
    if (v == '0) r = CAP_W'(1);
    if (v > CAP_W'(CAPACITY)) r = CAP_W'(CAPACITY);
    return r;
  endfunction

  acr_dir u_dir (
    .clk   (clk),
    .rst_n (rst_n),
    .flush (cfg_we),
    .go    (go_r),
    .cmd   (cmd_r),
    .done  (dir_done),
    .res   (dir_res)
  );

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign cfg_we    = cfg_valid && cfg_ready;
  assign c         = eff_cap(cap_r);
  assign l1        = {1'b0, cnt_r[L_T1]} + {1'b0, cnt_r[L_B1]};
  assign tot       = l1 + {1'b0, cnt_r[L_T2]} + {1'b0, cnt_r[L_B2]};
  assign t1        = cnt_r[L_T1];
  assign from_t1   = (t1 != '0) &&
                     ((in_b2_r && t1 == CNT_W'(tgt_r)) || t1 > CNT_W'(tgt_r));
  assign ghost     = (rep_list_r == L_T1) ? L_B1 : L_B2;

  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cap_r;
    tgt_nxt       = tgt_r;
    cnt_nxt       = cnt_r;
    key_nxt       = key_r;
    hold_idx_nxt  = hold_idx_r;
    hold_list_nxt = hold_list_r;
    hold_rank_nxt = hold_rank_r;
    miss_nxt      = miss_r;
    rep_nxt       = rep_r;
    in_b2_nxt     = in_b2_r;
    trim_en_nxt   = trim_en_r;
    trim_list_nxt = trim_list_r;
    rep_list_nxt  = rep_list_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    cmd_nxt       = cmd_r;
    go_nxt        = 1'b0;
    out_valid_nxt = 1'b0;
    pick          = from_t1 ? L_T1 : L_T2;
    if (cnt_r[pick] == '0) begin
      pick = from_t1 ? L_T2 : L_T1;
    end
    case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          cap_nxt = cfg_cache_capacity;
          cnt_nxt = '0;
          tgt_nxt = eff_cap(cfg_cache_capacity) >> 1;
        end
        if (start) begin
          key_nxt     = in_block_address;
          miss_nxt    = 1'b0;
          rep_nxt     = 1'b0;
          in_b2_nxt   = 1'b0;
          hit_nxt     = 1'b0;
          found_nxt   = F_NOWHERE;
          cmd_nxt.op  = OP_FIND;
          cmd_nxt.key = in_block_address;
          go_nxt      = 1'b1;
          state_nxt   = W_FIND;
        end
      end
      W_FIND: begin
        if (dir_done) begin
          if (dir_res.found) begin
            found_nxt     = {1'b0, dir_res.list};
            hold_idx_nxt  = dir_res.idx;
            hold_list_nxt = dir_res.list;
            hold_rank_nxt = dir_res.rank;
            case (dir_res.list)
              L_T1, L_T2: begin
                hit_nxt          = 1'b1;
                cmd_nxt.op       = OP_RELINK;
                cmd_nxt.idx      = dir_res.idx;
                cmd_nxt.old_list = dir_res.list;
                cmd_nxt.rank     = dir_res.rank;
                cmd_nxt.list     = L_T2;
                cmd_nxt.has_old  = 1'b1;
                cmd_nxt.has_new  = 1'b1;
                cnt_nxt[dir_res.list] = cnt_nxt[dir_res.list] - 1'b1;
                cnt_nxt[L_T2]         = cnt_nxt[L_T2] + 1'b1;
                go_nxt           = 1'b1;
                state_nxt        = W_FINAL;
              end
              L_B1: begin
                if (tgt_r < c) tgt_nxt = tgt_r + 1'b1;
                state_nxt = S_REP;
              end
              default: begin
                if (tgt_r != '0) tgt_nxt = tgt_r - 1'b1;
                in_b2_nxt = 1'b1;
                state_nxt = S_REP;
              end
            endcase
          end else begin
            miss_nxt = 1'b1;
            if (l1 >= (CNT_W + 1)'(c)) begin
              trim_en_nxt = 1'b1;
              if (t1 < CNT_W'(c)) begin
                trim_list_nxt = L_B1;
                rep_nxt       = 1'b1;
              end else begin
                trim_list_nxt = L_T1;
              end
              state_nxt = S_TRIM;
            end else if (tot >= (CNT_W + 1)'(c)) begin
              trim_en_nxt   = (tot >= ((CNT_W + 1)'(c) << 1));
              trim_list_nxt = L_B2;
              rep_nxt       = 1'b1;
              state_nxt     = S_TRIM;
            end else begin
              state_nxt = S_FREE;
            end
          end
        end
      end
      S_TRIM: begin
        if (trim_en_r && cnt_r[trim_list_r] != '0) begin
          cmd_nxt.op   = OP_LRU;
          cmd_nxt.list = trim_list_r;
          cmd_nxt.rank = RANK_W'(cnt_r[trim_list_r] - 1'b1);
          go_nxt       = 1'b1;
          state_nxt    = W_TRIM_LRU;
        end else begin
          state_nxt = rep_r ? S_REP : S_FREE;
        end
      end
      W_TRIM_LRU: begin
        if (dir_done) begin
          if (dir_res.found) begin
            cmd_nxt.op       = OP_RELINK;
            cmd_nxt.idx      = dir_res.idx;
            cmd_nxt.old_list = trim_list_r;
            cmd_nxt.rank     = RANK_W'(cnt_r[trim_list_r] - 1'b1);
            cmd_nxt.has_old  = 1'b1;
            cmd_nxt.has_new  = 1'b0;
            cnt_nxt[trim_list_r] = cnt_r[trim_list_r] - 1'b1;
            go_nxt           = 1'b1;
            state_nxt        = W_TRIM_UNL;
          end else begin
            state_nxt = rep_r ? S_REP : S_FREE;
          end
        end
      end
      W_TRIM_UNL: begin
        if (dir_done) begin
          state_nxt = rep_r ? S_REP : S_FREE;
        end
      end
      S_REP: begin
        if (cnt_r[pick] != '0) begin
          rep_list_nxt = pick;
          cmd_nxt.op   = OP_LRU;
          cmd_nxt.list = pick;
          cmd_nxt.rank = RANK_W'(cnt_r[pick] - 1'b1);
          go_nxt       = 1'b1;
          state_nxt    = W_REP_LRU;
        end else begin
          state_nxt = S_AFTER;
        end
      end
      W_REP_LRU: begin
        if (dir_done) begin
          if (dir_res.found) begin
            cmd_nxt.op       = OP_RELINK;
            cmd_nxt.idx      = dir_res.idx;
            cmd_nxt.old_list = rep_list_r;
            cmd_nxt.rank     = RANK_W'(cnt_r[rep_list_r] - 1'b1);
            cmd_nxt.list     = ghost;
            cmd_nxt.has_old  = 1'b1;
            cmd_nxt.has_new  = 1'b1;
            cnt_nxt[rep_list_r] = cnt_r[rep_list_r] - 1'b1;
            cnt_nxt[ghost]      = cnt_r[ghost] + 1'b1;
            if (!miss_r && hold_list_r == ghost) begin
              hold_rank_nxt = hold_rank_r + 1'b1;
            end
            go_nxt    = 1'b1;
            state_nxt = W_REP_MOVE;
          end else begin
            state_nxt = S_AFTER;
          end
        end
      end
      W_REP_MOVE: begin
        if (dir_done) begin
          state_nxt = S_AFTER;
        end
      end
      S_AFTER: begin
        if (miss_r) begin
          state_nxt = S_FREE;
        end else begin
          cmd_nxt.op       = OP_RELINK;
          cmd_nxt.idx      = hold_idx_r;
          cmd_nxt.old_list = hold_list_r;
          cmd_nxt.rank     = hold_rank_r;
          cmd_nxt.list     = L_T2;
          cmd_nxt.has_old  = 1'b1;
          cmd_nxt.has_new  = 1'b1;
          cnt_nxt[hold_list_r] = cnt_nxt[hold_list_r] - 1'b1;
          cnt_nxt[L_T2]        = cnt_nxt[L_T2] + 1'b1;
          go_nxt           = 1'b1;
          state_nxt        = W_FINAL;
        end
      end
      S_FREE: begin
        cmd_nxt.op = OP_FREE;
        go_nxt     = 1'b1;
        state_nxt  = W_FREE;
      end
      W_FREE: begin
        if (dir_done) begin
          if (dir_res.found) begin
            cmd_nxt.op      = OP_RELINK;
            cmd_nxt.idx     = dir_res.idx;
            cmd_nxt.key     = key_r;
            cmd_nxt.list    = L_T1;
            cmd_nxt.has_old = 1'b0;
            cmd_nxt.has_new = 1'b1;
            cnt_nxt[L_T1]   = cnt_r[L_T1] + 1'b1;
            go_nxt          = 1'b1;
            state_nxt       = W_FINAL;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      W_FINAL: begin
        if (dir_done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_W'(CAPACITY);
      tgt_r       <= CAP_W'(CAPACITY / 2);
      cnt_r       <= '0;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      tgt_r       <= tgt_nxt;
      cnt_r       <= cnt_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    hold_idx_r  <= hold_idx_nxt;
    hold_list_r <= hold_list_nxt;
    hold_rank_r <= hold_rank_nxt;
    miss_r      <= miss_nxt;
    rep_r       <= rep_nxt;
    in_b2_r     <= in_b2_nxt;
    trim_en_r   <= trim_en_nxt;
    trim_list_r <= trim_list_nxt;
    rep_list_r  <= rep_list_nxt;
    hit_r       <= hit_nxt;
    found_r     <= found_nxt;
    cmd_r       <= cmd_nxt;
    if (out_valid_nxt) begin
      out_hit_r   <= hit_r;
      out_found_r <= found_r;
      out_tgt_r   <= tgt_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_found_in     = out_found_r;
  assign out_target_after = out_tgt_r;

endmodule

FILE: sim/arc_cache_replacement_checker.sv
// arc cache replacement checker: watches the access, result and capacity channels,
// predicts each access result from its own copy of the directory and compares
// uses acr_pkg for found_in codes and widths
module arc_cache_replacement_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [acr_pkg::KEY_W-1:0]   in_block_address,
  input  logic                        out_valid,
  input  logic                        out_hit,
  input  logic [acr_pkg::FOUND_W-1:0] out_found_in,
  input  logic [acr_pkg::CAP_W-1:0]   out_target_after,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [acr_pkg::CAP_W-1:0]   cfg_cache_capacity,
  output int                          failures,
  output int                          pending
);
  import acr_pkg::*;

  localparam int DEPTH = 2 * CAPACITY;

  typedef enum int {SLOT_EMPTY, SLOT_T1, SLOT_T2, SLOT_B1, SLOT_B2} slot_list_e;

  typedef struct {
    logic               hit;
    logic [FOUND_W-1:0] found;
    logic [CAP_W-1:0]   target;
  } access_result_t;

  logic [KEY_W-1:0] dir_key  [DEPTH];
  slot_list_e       dir_list [DEPTH];
  int               dir_rank [DEPTH];
  int               list_len [5];
  int               t1_goal;
  int               cap_reg;
  access_result_t   result_q [$];

  function automatic int live_cap();
    return (cap_reg < 1) ? 1 : (cap_reg > CAPACITY ? CAPACITY : cap_reg);
  endfunction

  function automatic void flush_dir();
    for (int j = 0; j < DEPTH; j++) begin
      dir_list[j] = SLOT_EMPTY;
      dir_rank[j] = 0;
      dir_key[j]  = '0;
    end
    for (int l = 0; l < 5; l++) list_len[l] = 0;
    t1_goal = live_cap() / 2;
  endfunction

  function automatic void unlink(int i);
    slot_list_e l;
    int r;
    l = dir_list[i];
    r = dir_rank[i];
    if (l == SLOT_EMPTY) return;
    for (int j = 0; j < DEPTH; j++)
      if (dir_list[j] == l && dir_rank[j] > r) dir_rank[j]--;
    if (list_len[l] > 0) list_len[l]--;
    dir_list[i] = SLOT_EMPTY;
  endfunction

  function automatic void push_front(int i, slot_list_e l);
    for (int j = 0; j < DEPTH; j++)
      if (dir_list[j] == l) dir_rank[j]++;
    dir_rank[i] = 0;
    dir_list[i] = l;
    list_len[l]++;
  endfunction

  function automatic int oldest_in(slot_list_e l);
    if (list_len[l] == 0) return -1;
    for (int j = 0; j < DEPTH; j++)
      if (dir_list[j] == l && dir_rank[j] == list_len[l] - 1) return j;
    return -1;
  endfunction

  function automatic void demote(bit b2_hit);
    bit from_t1;
    int v;
    from_t1 = (list_len[SLOT_T1] >= 1) &&
              ((b2_hit && list_len[SLOT_T1] == t1_goal) || list_len[SLOT_T1] > t1_goal);
    v = oldest_in(from_t1 ? SLOT_T1 : SLOT_T2);
    if (v < 0) begin
      from_t1 = !from_t1;
      v = oldest_in(from_t1 ? SLOT_T1 : SLOT_T2);
    end
    if (v >= 0) begin
      unlink(v);
      push_front(v, from_t1 ? SLOT_B1 : SLOT_B2);
    end
  endfunction

  function automatic access_result_t arc_access(logic [KEY_W-1:0] addr);
    access_result_t res;
    int idx, c, l1, tot, v;
    c   = live_cap();
    idx = -1;
    for (int j = 0; j < DEPTH; j++)
      if (idx < 0 && dir_list[j] != SLOT_EMPTY && dir_key[j] == addr) idx = j;
    res.hit   = 1'b0;
    res.found = F_NOWHERE;
    if (idx >= 0) begin
      case (dir_list[idx])
        SLOT_T1, SLOT_T2: begin
          res.hit   = 1'b1;
          res.found = (dir_list[idx] == SLOT_T1) ? FOUND_W'(L_T1) : FOUND_W'(L_T2);
        end
        SLOT_B1: begin
          res.found = FOUND_W'(L_B1);
          if (t1_goal < c) t1_goal++;
          demote(1'b0);
        end
        default: begin
          res.found = FOUND_W'(L_B2);
          if (t1_goal > 0) t1_goal--;
          demote(1'b1);
        end
      endcase
      unlink(idx);
      push_front(idx, SLOT_T2);
    end else begin
      l1  = list_len[SLOT_T1] + list_len[SLOT_B1];
      tot = l1 + list_len[SLOT_T2] + list_len[SLOT_B2];
      if (l1 >= c) begin
        if (list_len[SLOT_T1] < c) begin
          v = oldest_in(SLOT_B1);
          if (v >= 0) unlink(v);
          demote(1'b0);
        end else begin
          v = oldest_in(SLOT_T1);
          if (v >= 0) unlink(v);
        end
      end else if (tot >= c) begin
        if (tot >= 2 * c) begin
          v = oldest_in(SLOT_B2);
          if (v >= 0) unlink(v);
        end
        demote(1'b0);
      end
      v = -1;
      for (int j = 0; j < DEPTH; j++)
        if (v < 0 && dir_list[j] == SLOT_EMPTY) v = j;
      if (v >= 0) begin
        dir_key[v] = addr;
        push_front(v, SLOT_T1);
      end
    end
    res.target = CAP_W'(t1_goal);
    return res;
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    if (!rst_n) begin
      cap_reg = CAPACITY;
      flush_dir();
      result_q.delete();
      failures <= 0;
    end else begin
      if (out_valid) begin
        if (result_q.size() == 0) begin
          failures <= failures + 1;
          if (failures < 10) $display("result beat with nothing expected at %0t", $time);
        end else begin
          want = result_q.pop_front();
          if (out_hit !== want.hit || out_found_in !== want.found ||
              out_target_after !== want.target) begin
            failures <= failures + 1;
            if (failures < 10)
              $display("mismatch at %0t: hit %0d/%0d found_in %0d/%0d target %0d/%0d",
                       $time, want.hit, out_hit, want.found, out_found_in,
                       want.target, out_target_after);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        cap_reg = cfg_cache_capacity;
        flush_dir();
      end
      if (start && !busy) result_q.push_back(arc_access(in_block_address));
    end
    pending <= result_q.size();
  end

endmodule

FILE: sim/arc_cache_replacement_test.sv
// arc cache replacement testbench top: clock, reset, access and capacity stimulus
// and verdict; uses acr_pkg, arc_cache_replacement and arc_cache_replacement_checker
module arc_cache_replacement_test;
  import acr_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [KEY_W-1:0]   in_block_address;
  logic               out_valid;
  logic               out_hit;
  logic [FOUND_W-1:0] out_found_in;
  logic [CAP_W-1:0]   out_target_after;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CAP_W-1:0]   cfg_cache_capacity;
  int                 failures;
  int                 pending;

  logic [KEY_W-1:0]   addr_pool [256];
  int                 pool_size;
  int                 accesses;
  int                 settings;
  bit                 gaps_on;

  arc_cache_replacement dut (.*);

  arc_cache_replacement_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_access(logic [KEY_W-1:0] addr);
    if (gaps_on && $urandom_range(99) < 29) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start            <= 1'b1;
    in_block_address <= addr;
    do @(posedge clk); while (busy);
    accesses++;
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while ((pending != 0 || busy) && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    drain();
    cfg_valid          <= 1'b1;
    cfg_cache_capacity <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings++;
    pool_size = 3 * ((cap == 0) ? 1 : (cap > CAPACITY ? CAPACITY : cap)) + 2;
    if (pool_size > 256) pool_size = 256;
    foreach (addr_pool[k]) addr_pool[k] = $urandom();
  endtask

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 8) send_access($urandom());
      else send_access(addr_pool[$urandom_range(pool_size - 1)]);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps [10];
    rst_n              <= 1'b0;
    start              <= 1'b0;
    in_block_address   <= '0;
    cfg_valid          <= 1'b0;
    cfg_cache_capacity <= '0;
    accesses = 0;
    settings = 0;
    gaps_on  = 1'b1;
    pool_size = 8;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default capacity, then small caches driven into both ghost lists, then capacities 0 and 127 (clamped)
    send_access('0);
    send_access('1);
    send_access('0);
    send_access('0);
    set_capacity(7'd2);
    foreach (addr_pool[k]) addr_pool[k] = k;
    send_access(32'h1);
    send_access(32'h1);
    send_access(32'h2);
    send_access(32'h3);
    send_access(32'h1);
    send_access(32'h4);
    send_access(32'h5);
    send_access(32'h2);
    send_access(32'h3);
    send_access(32'h4);
    set_capacity(7'd0);
    send_access(32'hFFFF_FFFF);
    send_access(32'h8000_0000);
    send_access(32'hFFFF_FFFF);
    set_capacity(7'd127);
    send_access(32'hA5A5_A5A5);
    send_access(32'h5A5A_5A5A);

    caps = '{7'd1, 7'd2, 7'd3, 7'd4, 7'd8, 7'd17, 7'd33, 7'd64, 7'd0, 7'd127};
    foreach (caps[s]) begin
      set_capacity(caps[s]);
      gaps_on = (s != 4);
      random_phase(115);
    end
    set_capacity(CAP_W'($urandom_range(1, 64)));
    random_phase(120);
    gaps_on = 1'b1;
    drain();

    $display("%0d accesses over %0d capacity settings (extremes and clamped values included)",
             accesses, settings);
    if (failures == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
